// ----- rtl/srt_pkg.sv -----
// shared types, constants and codes of the sorted region table checker
// no dependencies
`default_nettype none
package srt_pkg;

  localparam int ADDR_W          = 48;
  localparam int PAGE_SHIFT      = 12;
  localparam int PAGE_NUM_W      = ADDR_W - PAGE_SHIFT;
  localparam int MAX_REGIONS_DEF = 16;
  localparam int SLOT_W          = 4;
  localparam int OFFSET_W        = 36;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [2:0]        rights_t;
  typedef logic [1:0]        mode_t;
  typedef logic [2:0]        status_t;

  localparam addr_t PAGE_LOW  = addr_t'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam addr_t ADDR_MAX  = '1;
  localparam addr_t LIMIT_RST = 48'h7FFF_FFFF_F000;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_HOLE   = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;
  localparam mode_t MODE_CHECK  = 2'd3;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_NO_REGION  = 3'd1;
  localparam status_t ST_DENIED     = 3'd2;
  localparam status_t ST_FULL       = 3'd3;
  localparam status_t ST_NO_HOLE    = 3'd4;
  localparam status_t ST_MISALIGNED = 3'd5;

  typedef struct packed {
    addr_t   base;
    addr_t   len;
    rights_t rights;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EVAL,
    S_HOLE_RD,
    S_HOLE_END,
    S_HOLE_CMP,
    S_RM_RD,
    S_RM_EVAL,
    S_SH_RD,
    S_SH_WR,
    S_CK_RD,
    S_CK_EVAL,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/srt_if.sv -----
// valid/ready channel interfaces of the sorted region table checker
// depends on srt_pkg
`default_nettype none
interface srt_in_if;
  logic              valid;
  logic              ready;
  srt_pkg::mode_t    mode;
  srt_pkg::addr_t    address;
  srt_pkg::addr_t    length;
  srt_pkg::rights_t  permissions;
  srt_pkg::rights_t  access_kind;
  modport source (output valid, mode, address, length, permissions, access_kind,
                  input ready);
  modport sink   (input valid, mode, address, length, permissions, access_kind,
                  output ready);
endinterface

interface srt_out_if;
  logic                            valid;
  logic                            ready;
  srt_pkg::status_t                status;
  srt_pkg::addr_t                  result_address;
  logic [srt_pkg::SLOT_W-1:0]      region_slot;
  logic [srt_pkg::OFFSET_W-1:0]    page_offset;
  modport source (output valid, status, result_address, region_slot, page_offset,
                  input ready);
  modport sink   (input valid, status, result_address, region_slot, page_offset,
                  output ready);
endinterface

interface srt_cfg_if;
  logic           valid;
  logic           ready;
  srt_pkg::addr_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/sorted_region_table_checker.sv -----
// sorted region table checker top level: sequencer, region memory, result register
// depends on srt_pkg and the channel interfaces in srt_if.sv
`default_nettype none
// Keeps up to MAX_REGIONS address regions sorted by base in a one-port-read,
// one-port-write memory and runs one operation per input transfer: insert at an
// address, insert into a hole found below space_limit, remove an exact match, or
// check an access. A small sequencer walks the table one entry per step through
// a single compare/subtract path; each step is a registered memory read, then an
// evaluate; the hole search also registers the end-of-region add before the
// compare. The input is not ready while an item is in flight; the result sits
// in an output register, so a new item can be taken while a finished result
// still waits. Configuration (space_limit) is always ready and must only be
// written while the block is idle. No clearing pass is needed after reset:
// only entries below the count are ever read.
module sorted_region_table_checker #(
  parameter int MAX_REGIONS = srt_pkg::MAX_REGIONS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  srt_in_if.sink     in_ch,
  srt_out_if.source  out_ch,
  srt_cfg_if.sink    cfg_ch
);
  import srt_pkg::*;

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGIONS);

  // region memory, registered read
  entry_t          mem [MAX_REGIONS];
  entry_t          rd_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [IW-1:0]   mem_raddr;
  entry_t          mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // control and working registers
  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  addr_t           limit_r;
  addr_t           addr_r, addr_nxt;
  addr_t           len_r, len_nxt;
  rights_t         perm_r, perm_nxt;
  rights_t         acc_r, acc_nxt;
  logic [ADDR_W:0] size_r, size_nxt;       // rounded hole size, may reach 2^ADDR_W
  addr_t           va_r, va_nxt;           // hole candidate
  addr_t           lim_r, lim_nxt;         // hole upper bound
  addr_t           rva_r, rva_nxt;
  addr_t           rlim_r, rlim_nxt;
  status_t         st_r, st_nxt;
  addr_t           raddr_res_r, raddr_res_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [OFFSET_W-1:0] poff_r, poff_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  addr_t             out_addr_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [OFFSET_W-1:0] out_poff_r;
  logic              out_load;

  logic              in_xfer;
  logic [ADDR_W:0]   size_in;
  logic [ADDR_W:0]   end_sum;
  addr_t             rel;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // page-rounded hole size
  assign size_in = ({1'b0, in_ch.length} + {1'b0, PAGE_LOW}) & ~{1'b0, PAGE_LOW};
  // region end with carry for saturation
  assign end_sum = {1'b0, rd_q.base} + {1'b0, rd_q.len};
  assign rel     = addr_r - rd_q.base;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    perm_nxt      = perm_r;
    acc_nxt       = acc_r;
    size_nxt      = size_r;
    va_nxt        = va_r;
    lim_nxt       = lim_r;
    rva_nxt       = rva_r;
    rlim_nxt      = rlim_r;
    st_nxt        = st_r;
    raddr_res_nxt = raddr_res_r;
    slot_nxt      = slot_r;
    poff_nxt      = poff_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IW-1:0];
    mem_raddr     = idx_r[IW-1:0];
    mem_wdata     = '{base: addr_r, len: len_r, rights: perm_r};
    out_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          addr_nxt      = in_ch.address;
          len_nxt       = in_ch.length;
          perm_nxt      = in_ch.permissions;
          acc_nxt       = in_ch.access_kind;
          st_nxt        = ST_OK;
          raddr_res_nxt = '0;
          slot_nxt      = '0;
          poff_nxt      = '0;
          size_nxt      = size_in;
          case (in_ch.mode)
            MODE_INSERT: begin
              idx_nxt = count_r;
              if (count_r >= CNT_MAX) begin
                st_nxt    = ST_FULL;
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            MODE_HOLE: begin
              idx_nxt = count_r;
              va_nxt  = limit_r - size_in[ADDR_W-1:0];
              lim_nxt = limit_r;
              if (count_r >= CNT_MAX) begin
                st_nxt    = ST_FULL;
                state_nxt = S_FINISH;
              end else if (size_in > {1'b0, limit_r}) begin
                st_nxt    = ST_NO_HOLE;
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_HOLE_RD;
              end
            end
            MODE_REMOVE: begin
              idx_nxt = '0;
              if ((in_ch.address & PAGE_LOW) != '0) begin
                st_nxt    = ST_MISALIGNED;
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_RM_RD;
              end
            end
            default: begin
              idx_nxt   = '0;
              state_nxt = S_CK_RD;
            end
          endcase
        end
      end

      // sorted insert: shift larger bases up one slot, then drop the new entry in
      S_INS_RD: begin
        if (idx_r == '0) begin
          mem_we        = 1'b1;
          count_nxt     = count_r + 1'b1;
          raddr_res_nxt = addr_r;
          state_nxt     = S_FINISH;
        end else begin
          mem_raddr = IW'(idx_r - 1'b1);
          state_nxt = S_INS_EVAL;
        end
      end
      S_INS_EVAL: begin
        mem_we = 1'b1;
        if (rd_q.base > addr_r) begin
          mem_wdata = rd_q;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt     = count_r + 1'b1;
          raddr_res_nxt = addr_r;
          state_nxt     = S_FINISH;
        end
      end

      // hole search walks from the highest base down
      S_HOLE_RD: begin
        if (idx_r == '0) begin
          if (va_r == '0) begin
            st_nxt    = ST_NO_HOLE;
            state_nxt = S_FINISH;
          end else begin
            addr_nxt  = va_r;
            len_nxt   = size_r[ADDR_W-1:0];
            idx_nxt   = count_r;
            state_nxt = S_INS_RD;
          end
        end else begin
          mem_raddr = IW'(idx_r - 1'b1);
          state_nxt = S_HOLE_END;
        end
      end
      S_HOLE_END: begin
        rva_nxt   = rd_q.base;
        rlim_nxt  = end_sum[ADDR_W] ? ADDR_MAX : end_sum[ADDR_W-1:0];
        state_nxt = S_HOLE_CMP;
      end
      S_HOLE_CMP: begin
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_HOLE_RD;
        if (va_r <= rlim_r && rva_r < lim_r) begin
          if (size_r > {1'b0, rva_r}) begin
            st_nxt    = ST_NO_HOLE;
            state_nxt = S_FINISH;
          end else begin
            va_nxt  = rva_r - size_r[ADDR_W-1:0];
            lim_nxt = rva_r;
          end
        end
      end

      // remove: find the exact match, then close the gap
      S_RM_RD: begin
        if (idx_r == count_r) begin
          st_nxt    = ST_NO_REGION;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_RM_EVAL;
        end
      end
      S_RM_EVAL: begin
        if (rd_q.base == addr_r && rd_q.len == len_r) begin
          state_nxt = S_SH_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RM_RD;
        end
      end
      S_SH_RD: begin
        if ((idx_r + 1'b1) < count_r) begin
          mem_raddr = IW'(idx_r + 1'b1);
          state_nxt = S_SH_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_q;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_SH_RD;
      end

      // access check: first region holding the address
      S_CK_RD: begin
        if (idx_r == count_r) begin
          st_nxt    = ST_NO_REGION;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_CK_EVAL;
        end
      end
      S_CK_EVAL: begin
        if (addr_r >= rd_q.base && rel < rd_q.len) begin
          st_nxt    = ((acc_r & ~rd_q.rights) != '0) ? ST_DENIED : ST_OK;
          slot_nxt  = SLOT_W'(idx_r);
          poff_nxt  = OFFSET_W'(addr_r[ADDR_W-1:PAGE_SHIFT] - rd_q.base[ADDR_W-1:PAGE_SHIFT]);
          state_nxt = S_FINISH;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CK_RD;
        end
      end

      // hand the result over once the output register is free
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_r <= cfg_ch.data & ~PAGE_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    addr_r      <= addr_nxt;
    len_r       <= len_nxt;
    perm_r      <= perm_nxt;
    acc_r       <= acc_nxt;
    size_r      <= size_nxt;
    va_r        <= va_nxt;
    lim_r       <= lim_nxt;
    rva_r       <= rva_nxt;
    rlim_r      <= rlim_nxt;
    st_r        <= st_nxt;
    raddr_res_r <= raddr_res_nxt;
    slot_r      <= slot_nxt;
    poff_r      <= poff_nxt;
    if (out_load) begin
      out_status_r <= st_r;
      out_addr_r   <= raddr_res_r;
      out_slot_r   <= slot_r;
      out_poff_r   <= poff_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.region_slot    = out_slot_r;
  assign out_ch.page_offset    = out_poff_r;

`ifndef SYNTHESIS
  // table never holds more regions than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("region count above capacity");

  // the count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
                      count_r == $past(count_r) - 1'b1))
    else $error("region count jumped");

  // an accepted item keeps the input closed in the next cycle
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input ready right after a transfer");

  // a result is only loaded when the output register is free or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_sorted_region_table_checker.sv -----
// self-checking testbench for sorted_region_table_checker: directed table, then random traffic
// depends on srt_pkg, the channel interfaces in srt_if.sv and the rtl top level
module tb_sorted_region_table_checker;
  import srt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  srt_in_if  in_ch ();
  srt_out_if out_ch ();
  srt_cfg_if cfg_ch ();

  sorted_region_table_checker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  typedef struct {
    mode_t   mode;
    addr_t   address;
    addr_t   length;
    rights_t permissions;
    rights_t access_kind;
  } request_t;

  typedef struct packed {
    status_t                status;
    addr_t                  result_address;
    logic [SLOT_W-1:0]      region_slot;
    logic [OFFSET_W-1:0]    page_offset;
  } answer_t;

  // directed rows; a known answer is typed in where it is obvious
  typedef struct {
    request_t req;
    bit       known;
    answer_t  ans;
  } dir_row_t;

  // shadow copy of the region table
  addr_t   tbl_base [MAX_REGIONS_DEF];
  addr_t   tbl_len  [MAX_REGIONS_DEF];
  rights_t tbl_rights [MAX_REGIONS_DEF];
  int      tbl_count;
  addr_t   limit_shadow;

  answer_t answer_queue[$];
  int      mismatch_count = 0;
  bit      no_idle = 0;

  function automatic addr_t region_top(int i);
    logic [48:0] e;
    e = {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
    return e[48] ? ADDR_MAX : e[47:0];
  endfunction

  function automatic void place_region(addr_t b, addr_t l, rights_t r);
    int pos;
    pos = tbl_count;
    while (pos > 0 && tbl_base[pos-1] > b) begin
      tbl_base[pos] = tbl_base[pos-1];
      tbl_len[pos] = tbl_len[pos-1];
      tbl_rights[pos] = tbl_rights[pos-1];
      pos--;
    end
    tbl_base[pos] = b;
    tbl_len[pos] = l;
    tbl_rights[pos] = r;
    tbl_count++;
  endfunction

  // downward hole search from the limit; returns 0 when none
  function automatic addr_t search_hole(logic [48:0] size);
    logic [48:0] va, lim, rva, rlim;
    if (size > limit_shadow) return '0;
    va = limit_shadow - size;
    lim = limit_shadow;
    for (int i = tbl_count; i > 0; i--) begin
      rva = tbl_base[i-1];
      rlim = region_top(i-1);
      if (va <= rlim && rva < lim) begin
        if (size > rva) return '0;
        va = rva - size;
        lim = rva;
      end
    end
    return va[47:0];
  endfunction

  function automatic answer_t table_op(request_t q);
    answer_t a;
    logic [48:0] size;
    addr_t hole;
    a = '{ST_OK, '0, '0, '0};
    case (q.mode)
      MODE_INSERT: begin
        if (tbl_count >= MAX_REGIONS_DEF) a.status = ST_FULL;
        else begin
          place_region(q.address, q.length, q.permissions);
          a.result_address = q.address;
        end
      end
      MODE_HOLE: begin
        size = ({1'b0, q.length} + 49'(PAGE_LOW)) & ~49'(PAGE_LOW);
        if (tbl_count >= MAX_REGIONS_DEF) a.status = ST_FULL;
        else begin
          hole = search_hole(size);
          if (hole == '0) a.status = ST_NO_HOLE;
          else begin
            place_region(hole, size[47:0], q.permissions);
            a.result_address = hole;
          end
        end
      end
      MODE_REMOVE: begin
        if ((q.address & PAGE_LOW) != '0) a.status = ST_MISALIGNED;
        else begin
          a.status = ST_NO_REGION;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_base[i] == q.address && tbl_len[i] == q.length) begin
              for (int k = i; k + 1 < tbl_count; k++) begin
                tbl_base[k] = tbl_base[k+1];
                tbl_len[k] = tbl_len[k+1];
                tbl_rights[k] = tbl_rights[k+1];
              end
              tbl_count--;
              a.status = ST_OK;
              break;
            end
          end
        end
      end
      default: begin
        a.status = ST_NO_REGION;
        for (int i = 0; i < tbl_count; i++) begin
          if (q.address >= tbl_base[i] && q.address - tbl_base[i] < tbl_len[i]) begin
            a.status = ((q.access_kind & ~tbl_rights[i]) != '0) ? ST_DENIED : ST_OK;
            a.region_slot = i[SLOT_W-1:0];
            a.page_offset = OFFSET_W'((q.address >> PAGE_SHIFT)
                                      - (tbl_base[i] >> PAGE_SHIFT));
            break;
          end
        end
      end
    endcase
    return a;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 12);
  endfunction

  // one request transfer; the expectation is queued at the accepting edge
  task automatic send_request(request_t q, bit known, answer_t fixed);
    answer_t a;
    while (idle_now()) @(posedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= q.mode;
    in_ch.address     <= q.address;
    in_ch.length      <= q.length;
    in_ch.permissions <= q.permissions;
    in_ch.access_kind <= q.access_kind;
    do @(posedge clk); while (!in_ch.ready);
    a = table_op(q);
    if (known && a != fixed) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("table row disagrees with prediction: row %p pred %p", fixed, a);
    end
    answer_queue.push_back(a);
    in_ch.valid <= 1'b0;
    // block stays busy for at least this cycle anyway
    @(posedge clk);
  endtask

  task automatic write_limit(addr_t v);
    wait (answer_queue.size() == 0);
    repeat (120) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    limit_shadow = v & ~PAGE_LOW;
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (answer_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transfer");
      end else begin
        answer_t e;
        e = answer_queue.pop_front();
        if (out_ch.status !== e.status || out_ch.result_address !== e.result_address ||
            out_ch.region_slot !== e.region_slot ||
            out_ch.page_offset !== e.page_offset) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: exp %0d %h %0d %h got %0d %h %0d %h",
                     e.status, e.result_address, e.region_slot, e.page_offset,
                     out_ch.status, out_ch.result_address, out_ch.region_slot,
                     out_ch.page_offset);
        end
      end
    end
    out_ch.ready <= !idle_now();
  end

  function automatic request_t mk(mode_t m, addr_t ad, addr_t ln, rights_t p, rights_t k);
    request_t q;
    q.mode = m; q.address = ad; q.length = ln; q.permissions = p; q.access_kind = k;
    return q;
  endfunction

  // random address, mostly near one of a few clusters so regions collide and nest
  function automatic addr_t pick_addr();
    case ($urandom_range(3))
      0: return addr_t'({$urandom, $urandom});
      1: return addr_t'($urandom_range(32'h0010_0000)) & ~PAGE_LOW;
      2: return limit_shadow - addr_t'($urandom_range(32'h0008_0000));
      default: return (tbl_count > 0)
        ? tbl_base[$urandom_range(tbl_count-1)] + addr_t'($urandom_range(8191))
        : addr_t'($urandom_range(65535));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t q;
    int pick, i;
    q.permissions = rights_t'($urandom);
    q.access_kind = rights_t'($urandom);
    pick = $urandom_range(99);
    q.length = ($urandom_range(9) == 0) ? addr_t'({$urandom, $urandom})
                                        : addr_t'($urandom_range(32'h6000));
    q.address = pick_addr();
    if (pick < 22) q.mode = MODE_INSERT;
    else if (pick < 42) q.mode = MODE_HOLE;
    else if (pick < 60) begin
      q.mode = MODE_REMOVE;
      // mostly exact matches of live regions
      if (tbl_count > 0 && $urandom_range(3) != 0) begin
        i = $urandom_range(tbl_count-1);
        q.address = tbl_base[i];
        q.length = tbl_len[i];
      end
    end else q.mode = MODE_CHECK;
    return q;
  endfunction

  dir_row_t dir_rows[$];
  answer_t  none_a;

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = MODE_INSERT; in_ch.address = '0;
    in_ch.length = '0; in_ch.permissions = '0; in_ch.access_kind = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    limit_shadow = LIMIT_RST;
    tbl_count = 0;
    none_a = '{ST_OK, '0, '0, '0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty table cases, extremes, each mode
    dir_rows.push_back('{mk(MODE_CHECK, '0, '0, 3'd0, 3'd7), 1,
                         '{ST_NO_REGION, '0, '0, '0}});
    dir_rows.push_back('{mk(MODE_REMOVE, 48'h1001, '0, 3'd0, 3'd0), 1,
                         '{ST_MISALIGNED, '0, '0, '0}});
    dir_rows.push_back('{mk(MODE_REMOVE, 48'h1000, 48'h1000, 3'd0, 3'd0), 1,
                         '{ST_NO_REGION, '0, '0, '0}});
    dir_rows.push_back('{mk(MODE_HOLE, '0, 48'h1, 3'd7, 3'd0), 1,
                         '{ST_OK, 48'h7FFF_FFFF_E000, '0, '0}});
    dir_rows.push_back('{mk(MODE_INSERT, ADDR_MAX, ADDR_MAX, 3'd5, 3'd0), 1,
                         '{ST_OK, ADDR_MAX, '0, '0}});
    dir_rows.push_back('{mk(MODE_INSERT, '0, '0, 3'd0, 3'd0), 1,
                         '{ST_OK, '0, '0, '0}});
    dir_rows.push_back('{mk(MODE_INSERT, 48'h5000, 48'h3000, 3'd1, 3'd0), 0, none_a});
    dir_rows.push_back('{mk(MODE_INSERT, 48'h5000, 48'h10, 3'd6, 3'd0), 0, none_a});
    dir_rows.push_back('{mk(MODE_CHECK, 48'h7FFF, '0, 3'd0, 3'd1), 0, none_a});
    dir_rows.push_back('{mk(MODE_CHECK, 48'h7FFF, '0, 3'd0, 3'd2), 0, none_a});
    dir_rows.push_back('{mk(MODE_CHECK, 48'h7FFF_FFFF_E123, '0, 3'd0, 3'd4), 0, none_a});
    dir_rows.push_back('{mk(MODE_CHECK, 48'h8000, '0, 3'd0, 3'd0), 0, none_a});
    dir_rows.push_back('{mk(MODE_HOLE, '0, ADDR_MAX, 3'd3, 3'd0), 0, none_a});
    dir_rows.push_back('{mk(MODE_HOLE, '0, '0, 3'd3, 3'd0), 0, none_a});
    dir_rows.push_back('{mk(MODE_HOLE, '0, 48'h7FFF_FFFF_D000, 3'd2, 3'd0), 0, none_a});
    dir_rows.push_back('{mk(MODE_REMOVE, 48'h5000, 48'h3000, 3'd0, 3'd0), 0, none_a});
    dir_rows.push_back('{mk(MODE_CHECK, ADDR_MAX - 48'h1, '0, 3'd0, 3'd5), 0, none_a});
    foreach (dir_rows[r]) send_request(dir_rows[r].req, dir_rows[r].known, dir_rows[r].ans);
    // fill to full, then both insert modes must refuse
    while (tbl_count < MAX_REGIONS_DEF)
      send_request(mk(MODE_INSERT, pick_addr(), 48'h2000, 3'd7, 3'd0), 0, none_a);
    send_request(mk(MODE_INSERT, 48'h1234, 48'h1, 3'd1, 3'd0), 1,
                 '{ST_FULL, '0, '0, '0});
    send_request(mk(MODE_HOLE, '0, 48'h1, 3'd1, 3'd0), 1, '{ST_FULL, '0, '0, '0});

    // random phases with several limits, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_limit('0);
        1: write_limit(ADDR_MAX);
        2: write_limit(48'h0000_0010_0fff);
        3: write_limit(LIMIT_RST);
        default: write_limit(addr_t'({$urandom, $urandom}));
      endcase
      no_idle = (ph == 3);
      for (int n = 0; n < 250; n++) begin
        // drain the table now and then so inserts keep working
        if (tbl_count == MAX_REGIONS_DEF && $urandom_range(1))
          send_request(mk(MODE_REMOVE, tbl_base[0], tbl_len[0], 3'd0, 3'd0), 0, none_a);
        else
          send_request(random_request(), 0, none_a);
      end
    end
    no_idle = 0;

    wait (answer_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
